@@ rtl/shs_pkg.sv @@
// shared types and constants for the sha-256 stream hash unit
package shs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;
  } shs_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shs_out_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/shs_ram.sv @@
// generic ram with one write port and one registered read port
module shs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/shs_fifo.sv @@
// small item queue between the input front and the hash engine
module shs_fifo import shs_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  shs_in_t push_data,
  output logic    full,
  input  logic    pop,
  output shs_in_t pop_data,
  output logic    empty
);
  localparam int Aw = $clog2(Depth);
  shs_in_t        slots [Depth];
  logic [Aw-1:0]  wptr, rptr;
  logic [Aw:0]    count;

  assign full = count == (Aw+1)'(Depth);
  assign empty = count == '0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= push_data;
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (pop && !empty) rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + 1'b1;
      count <= count + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
    end
  end
endmodule

@@ rtl/shs_front.sv @@
// input front: takes transfers and queues every item that carries work
module shs_front import shs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  shs_in_t in_data,
  output shs_in_t q_data,
  output logic    q_empty,
  input  logic    q_pop
);
  logic full, keep;

  assign in_ready = !full;
  // idle items carry no work and are dropped here
  assign keep = in_data.has_data || in_data.last_byte;

  shs_fifo #(.Depth(4)) u_fifo (
    .clk(clk), .rst(rst),
    .push(in_valid && keep), .push_data(in_data), .full(full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );
endmodule

@@ rtl/shs_engine.sv @@
// hash engine: block buffer, padding, round loop and digest output
module shs_engine import shs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  shs_in_t  q_data,
  input  logic     q_empty,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output shs_out_t out_data
);
  typedef enum logic [2:0] {
    S_TAKE, S_PAD, S_LEN, S_LOAD, S_ROUND, S_FOLD, S_EMIT
  } state_t;

  state_t       state;
  logic [5:0]   fill_count;
  logic [60:0]  message_bytes;
  logic [63:0]  bits;
  logic         finishing;
  logic         pad_done;
  logic         state_len_done;
  logic [31:0]  hash_words [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [6:0]   rnd;
  logic [2:0]   widx;

  // buffer ram
  logic         we;
  logic [5:0]   waddr, raddr;
  logic [7:0]   wdata, rdata;

  shs_ram #(.Width(8), .Depth(64)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] s0, s1, wnew, big0, big1, ch, maj, t1, t2;
  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
    big1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + big1 + ch + RoundK[rnd[5:0]] + w[0];
    big0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = big0 + maj;
  end

  // byte writes come from the take, pad and length states
  always_comb begin
    we = 1'b0;
    waddr = fill_count;
    wdata = '0;
    case (state)
      S_TAKE: begin
        we = !q_empty && q_data.has_data;
        wdata = q_data.data_byte;
      end
      S_PAD: begin
        we = 1'b1;
        wdata = pad_done ? 8'h00 : PadByte;
      end
      S_LEN: begin
        we = 1'b1;
        wdata = bits[8*(7 - fill_count[2:0]) +: 8];
      end
      default: ;
    endcase
  end
  assign raddr = rnd[5:0];
  assign q_pop = state == S_TAKE && !q_empty;
  assign out_valid = state == S_EMIT;
  assign out_data = '{digest_word: hash_words[widx], word_index: widx,
                      last_word: widx == 3'd7};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      fill_count <= '0;
      message_bytes <= '0;
      finishing <= 1'b0;
      pad_done <= 1'b0;
      rnd <= '0;
      widx <= '0;
      for (int i = 0; i < 8; i++) hash_words[i] <= InitHash[i];
    end else begin
      case (state)
        S_TAKE: if (!q_empty) begin
          if (q_data.has_data) begin
            fill_count <= fill_count + 1'b1;
            message_bytes <= message_bytes + 1'b1;
          end
          bits <= {message_bytes + 61'(q_data.has_data), 3'b000};
          finishing <= q_data.last_byte;
          if (q_data.has_data && fill_count == 6'd63) begin
            state <= S_LOAD;
            rnd <= '0;
          end else if (q_data.last_byte) begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          // pad_done low marks the 0x80 byte not yet written
          pad_done <= 1'b1;
          fill_count <= fill_count + 1'b1;
          if (fill_count == 6'd63) begin
            state <= S_LOAD;
            rnd <= '0;
          end else if (fill_count + 1'b1 == LenStart) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          fill_count <= fill_count + 1'b1;
          if (fill_count == 6'd63) begin
            state <= S_LOAD;
            rnd <= '0;
          end
        end
        S_LOAD: begin
          // prime the ram read and the working variables
          for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
          rnd <= 7'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          // rnd 1..64 shifts the block bytes into the schedule window
          if (rnd <= 7'd64) begin
            for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
            w[15] <= {w[15][23:0], rdata};
          end
          rnd <= rnd + 1'b1;
          if (rnd == 7'd64) begin
            rnd <= '0;
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          // rounds: w[0] is the current schedule word
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          rnd <= rnd + 1'b1;
          if (rnd == 7'd64) begin
            for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + v[i];
            rnd <= '0;
            if (finishing && fill_count == 6'd0 && state_len_done) begin
              widx <= '0;
              state <= S_EMIT;
            end else if (finishing) begin
              state <= S_PAD;
            end else begin
              state <= S_TAKE;
            end
          end
        end
        S_EMIT: if (out_ready) begin
          widx <= widx + 1'b1;
          if (widx == 3'd7) begin
            for (int i = 0; i < 8; i++) hash_words[i] <= InitHash[i];
            fill_count <= '0;
            message_bytes <= '0;
            finishing <= 1'b0;
            pad_done <= 1'b0;
            state <= S_TAKE;
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end

  // set once the length bytes have gone into the block under way
  always_ff @(posedge clk) begin
    if (rst) state_len_done <= 1'b0;
    else if (state == S_LEN) state_len_done <= 1'b1;
    else if (state == S_EMIT) state_len_done <= 1'b0;
  end
endmodule

@@ rtl/sha256_stream_hash_unit.sv @@
// top level of the sha-256 stream hash unit
//  channel | direction | payload
//  in      | input     | shs_in_t  (data_byte, has_data, last_byte)
//  out     | output    | shs_out_t (digest_word, word_index, last_word)
// the engine takes data bytes only in its take state; a full block then adds a ram read-in of 64
// bytes and the round loop, one round per cycle.
// finishing adds padding writes, one or two blocks and eight output transfers.
// a four-entry queue lets input transfers continue while the engine is busy.
// reset is synchronous and restores the initial hash values.
module sha256_stream_hash_unit import shs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  shs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output shs_out_t out_data
);
  shs_in_t q_data;
  logic    q_empty, q_pop;

  shs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop)
  );

  shs_engine u_engine (
    .clk(clk), .rst(rst), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

@@ rtl/shs_checker.sv @@
// port-level checks for the sha-256 stream hash unit, bound to the top level
module shs_checker import shs_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input shs_out_t out_data
);
  a_ready_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(in_ready))
    else $error("in_ready unknown");
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> out_data.word_index == 3'd0)
    else $error("digest did not start at word zero");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.last_word == (out_data.word_index == 3'd7))
    else $error("last_word flag wrong");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.word_index != 3'd7 |=>
    out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest words not consecutive");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");
endmodule

bind sha256_stream_hash_unit shs_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
